@@ rtl/button_ladder_min_hold_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the button ladder block
// Clocked on clk_i; the checked form is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_LADDER_MIN_HOLD_UNIT_MACROS_SVH
`define BUTTON_LADDER_MIN_HOLD_UNIT_MACROS_SVH

// Check a property out of reset.
`define BLMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BLMH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/blmh_pkg.sv @@
// ----------------------------------------------------------------------------
// blmh_pkg
// Types, register codes and reset constants of the button ladder block.
// ----------------------------------------------------------------------------
`default_nettype none

package blmh_pkg;

  localparam int NumButtonsDefault = 4;
  localparam int NumLevels         = 4;
  localparam int LevelW            = 12;
  localparam int CountW            = 4;
  localparam int MaskW             = 4;
  localparam int IdxW              = 2;
  localparam int RegCount          = 6;
  localparam int RegIdxW           = $clog2(RegCount);
  localparam int CfgDataW          = LevelW;

  localparam logic [CountW-1:0] SampleMax = 4'd15;

  localparam logic [LevelW-1:0] ResetIdle    = 12'd3300;
  localparam logic [LevelW-1:0] ResetLevel0  = 12'd0;
  localparam logic [LevelW-1:0] ResetLevel1  = 12'd800;
  localparam logic [LevelW-1:0] ResetLevel2  = 12'd1600;
  localparam logic [LevelW-1:0] ResetLevel3  = 12'd2400;
  localparam logic [CountW-1:0] ResetMinHold = 4'd2;

  typedef enum logic [RegIdxW-1:0] {
    REG_IDLE_LEVEL = 3'd0,
    REG_LEVEL0     = 3'd1,
    REG_LEVEL1     = 3'd2,
    REG_LEVEL2     = 3'd3,
    REG_LEVEL3     = 3'd4,
    REG_MIN_HOLD   = 3'd5
  } blmh_reg_e;

  typedef enum logic {
    KIND_EVENT = 1'b0,
    KIND_TICK  = 1'b1
  } blmh_kind_e;

  typedef struct packed {
    logic [LevelW-1:0]                idle;
    logic [NumLevels-1:0][LevelW-1:0] level;
    logic [CountW-1:0]                min_hold;
  } blmh_cfg_t;

  typedef struct packed {
    blmh_kind_e      kind;
    logic [IdxW-1:0] idx;
    logic            pressed;
  } blmh_item_t;

  typedef struct packed {
    logic [MaskW-1:0]  mask;
    logic [LevelW-1:0] level;
  } blmh_result_t;

endpackage

`default_nettype wire

@@ rtl/button_ladder_min_hold_unit.sv @@
// ----------------------------------------------------------------------------
// button_ladder_min_hold_unit
// Minimum-hold stretcher for up to four buttons with a resistor-ladder level.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transaction is a button event (tuser = 0, tdata holds
//   the button index and the pressed flag) or a sample tick (tuser = 1).
//   Output stream: one transaction per input, carrying the ladder level and
//   the mask of held buttons.
//   Path: an accepted item is loaded into the input register, then into the
//   output register once that is empty or being read.
//   Throughput: one item per cycle while m_axis_tready is held high; the
//   per-button hold state is updated as each item advances.
//   Configuration: plain write port, index 0 idle level, 1..4 button levels,
//   5 minimum hold samples; write only while the pipeline is empty.
//   Reset: all buttons released, counts zero, registers at their defaults,
//   stored level at the idle default.
//   Stall: with m_axis_tready low the output holds, the input register fills
//   and then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module button_ladder_min_hold_unit #(
  parameter int NUM_BUTTONS = blmh_pkg::NumButtonsDefault
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [blmh_pkg::RegIdxW-1:0]     cfg_index_i,
  input  wire  [blmh_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [7:0]                       s_axis_tdata,  // [1:0] button_index, [2] pressed
  input  wire                              s_axis_tuser,  // [0] kind
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [15:0]                      m_axis_tdata   // [11:0] level_mv, [15:12] held_mask
);
  import blmh_pkg::*;

  `include "button_ladder_min_hold_unit_macros.svh"

  blmh_cfg_t    cfg_q;
  blmh_item_t   in_q;
  logic         in_valid_q;
  blmh_result_t out_q, result;
  logic         out_valid_q;
  logic         advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle     <= ResetIdle;
      cfg_q.level[0] <= ResetLevel0;
      cfg_q.level[1] <= ResetLevel1;
      cfg_q.level[2] <= ResetLevel2;
      cfg_q.level[3] <= ResetLevel3;
      cfg_q.min_hold <= ResetMinHold;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IDLE_LEVEL: cfg_q.idle     <= cfg_data_i;
        REG_LEVEL0:     cfg_q.level[0] <= cfg_data_i;
        REG_LEVEL1:     cfg_q.level[1] <= cfg_data_i;
        REG_LEVEL2:     cfg_q.level[2] <= cfg_data_i;
        REG_LEVEL3:     cfg_q.level[3] <= cfg_data_i;
        REG_MIN_HOLD:   cfg_q.min_hold <= cfg_data_i[CountW-1:0];
        default:        ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.kind    <= blmh_kind_e'(s_axis_tuser);
      in_q.idx     <= s_axis_tdata[IdxW-1:0];
      in_q.pressed <= s_axis_tdata[IdxW];
    end
  end

  blmh_buttons #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_buttons (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.mask, out_q.level};

  `BLMH_ASSERT(a_stall_blocks_advance, out_valid_q && !m_axis_tready |-> !advance, "overrun")
  `BLMH_ASSERT(a_advance_fills_output, advance |=> out_valid_q, "advanced item lost")
  `BLMH_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "output valid in reset")

endmodule

`default_nettype wire

@@ rtl/blmh_buttons.sv @@
// ----------------------------------------------------------------------------
// blmh_buttons
// Per-button hold state, sample counting and ladder level selection.
// ----------------------------------------------------------------------------
`default_nettype none

module blmh_buttons #(
  parameter int NUM_BUTTONS = blmh_pkg::NumButtonsDefault
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   advance_i,
  input  blmh_pkg::blmh_item_t   item_i,
  input  blmh_pkg::blmh_cfg_t    cfg_i,
  output blmh_pkg::blmh_result_t result_o
);
  import blmh_pkg::*;

  logic [NUM_BUTTONS-1:0]             held_q, held_d;
  logic [NUM_BUTTONS-1:0]             pend_q, pend_d;
  logic [NUM_BUTTONS-1:0][CountW-1:0] cnt_q, cnt_d;
  logic [LevelW-1:0]                  cur_level_q, level_d;
  logic [NUM_BUTTONS-1:0][LevelW-1:0] btn_level;
  logic [MaskW-1:0]                   mask;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lvl
    if (g < NumLevels) begin : g_reg
      assign btn_level[g] = cfg_i.level[g];
    end else begin : g_idle
      assign btn_level[g] = cfg_i.idle;
    end
  end

  always_comb begin
    logic [CountW-1:0] inc;
    inc    = '0;
    held_d = held_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (item_i.kind == KIND_TICK) begin
        if (held_q[i]) begin
          inc      = (cnt_q[i] < SampleMax) ? cnt_q[i] + 1'b1 : cnt_q[i];
          cnt_d[i] = inc;
          if (pend_q[i] && inc >= cfg_i.min_hold) begin
            held_d[i] = 1'b0;
            pend_d[i] = 1'b0;
          end
        end
      end else if (int'(item_i.idx) == i) begin
        if (item_i.pressed) begin
          held_d[i] = 1'b1;
          pend_d[i] = 1'b0;
          cnt_d[i]  = '0;
        end else if (held_q[i]) begin
          if (cnt_q[i] >= cfg_i.min_hold) begin
            held_d[i] = 1'b0;
            pend_d[i] = 1'b0;
          end else begin
            pend_d[i] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    logic found;
    found   = 1'b0;
    level_d = cfg_i.idle;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (held_d[i] && !found) begin
        found   = 1'b1;
        level_d = btn_level[i];
      end
    end
  end

  for (genvar g = 0; g < MaskW; g++) begin : g_mask
    if (g < NUM_BUTTONS) begin : g_on
      assign mask[g] = held_d[g];
    end else begin : g_off
      assign mask[g] = 1'b0;
    end
  end

  assign result_o.level = (item_i.kind == KIND_TICK) ? cur_level_q : level_d;
  assign result_o.mask  = mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      pend_q      <= '0;
      cnt_q       <= '0;
      cur_level_q <= ResetIdle;
    end else if (advance_i) begin
      held_q      <= held_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      cur_level_q <= level_d;
    end
  end

endmodule

`default_nettype wire
